// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: lbl");
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/mies_pkg.sv =====
// ----------------------------------------------------------------------------
// mies_pkg
// Types and codes shared by the execute step controller and datapath.
// ----------------------------------------------------------------------------
package mies_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned RegIdxWidth = 5;
   localparam int unsigned DivCountWidth = 6;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_MEMORY  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [5:0] {
      OP_SPECIAL = 6'h00, OP_J     = 6'h02, OP_JAL   = 6'h03, OP_BEQ   = 6'h04,
      OP_BNE     = 6'h05, OP_BLEZ  = 6'h06, OP_BGTZ  = 6'h07, OP_ADDI  = 6'h08,
      OP_ADDIU   = 6'h09, OP_SLTI  = 6'h0A, OP_SLTIU = 6'h0B, OP_ANDI  = 6'h0C,
      OP_ORI     = 6'h0D, OP_XORI  = 6'h0E, OP_LLO   = 6'h18, OP_LHI   = 6'h19,
      OP_LB      = 6'h20, OP_LH    = 6'h21, OP_LW    = 6'h23, OP_LBU   = 6'h24,
      OP_LHU     = 6'h25, OP_SB    = 6'h28, OP_SH    = 6'h29, OP_SW    = 6'h2B
   } opcode_type;

   typedef enum logic [5:0] {
      FN_SLL  = 6'h00, FN_SRL  = 6'h02, FN_SRA   = 6'h03, FN_SLLV = 6'h04,
      FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR    = 6'h08, FN_JALR = 6'h09,
      FN_MFHI = 6'h10, FN_MTHI = 6'h11, FN_MFLO  = 6'h12, FN_MTLO = 6'h13,
      FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV  = 6'h1A, FN_DIVU = 6'h1B,
      FN_ADD  = 6'h20, FN_ADDU = 6'h21, FN_SUB   = 6'h22, FN_SUBU = 6'h23,
      FN_AND  = 6'h24, FN_OR   = 6'h25, FN_XOR   = 6'h26, FN_NOR  = 6'h27,
      FN_SLT  = 6'h2A, FN_SLTU = 6'h2B
   } funct_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_instr;
      logic read_regs;
      logic exec;
      logic mul_start;
      logic mul_finish;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_last;
   } stat_type;

endpackage

// ===== rtl/core/mies_ctrl.sv =====
// ----------------------------------------------------------------------------
// mies_ctrl
// Sequencer: fetch operands, execute, iterate multiply/divide, deliver.
// ----------------------------------------------------------------------------
module mies_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mies_pkg::stat_type stat,
   output mies_pkg::cmd_type  cmd
);
   import mies_pkg::*;
   `include "assert_macros.svh"

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_instr = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_regs = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.is_mul) begin
               cmd.mul_start = 1'b1;
               state_in = ST_MUL;
            end else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul_finish = 1'b1;
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            if (stat.div_last) begin
               cmd.div_finish = 1'b1;
               cmd.exec = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_IMPL(a_one_phase, clock, reset, !(req_ready && rsp_valid))
   `ASSERT_IMPL(a_commit_hs, clock, reset, cmd.commit |-> (rsp_valid && rsp_ready))
   `ASSERT_IMPL(a_accept_read, clock, reset, (req_valid && req_ready) |=> cmd.read_regs)
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE))

endmodule

// ===== rtl/core/mies_dp.sv =====
// ----------------------------------------------------------------------------
// mies_dp
// Register file, HI/LO, PC, ALU, split partial-product multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
module mies_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             req_instruction_word,
   input  logic                    csr_write,
   input  logic [31:0]             csr_start_pc,
   input  mies_pkg::cmd_type       cmd,
   output mies_pkg::stat_type      stat,
   output logic [31:0]             rsp_next_pc,
   output logic                    rsp_reg_written,
   output logic [4:0]              rsp_reg_index,
   output logic [31:0]             rsp_reg_value,
   output logic [1:0]              rsp_status
);
   import mies_pkg::*;

   logic [31:0] rf_mem [32];
   logic [31:0] valid_ff;   // entry written since reset
   logic [31:0] instr_ff;
   logic [31:0] a_ff, b_ff, a_raw, b_raw;
   logic [31:0] hi_ff, lo_ff, pc_ff;
   logic [31:0] hi_in, lo_in;
   logic        hilo_we;
   logic [31:0] npc_ff, npc_in, val_ff, val_in;
   logic        wr_ff, wr_in;
   logic [4:0]  dst_ff, dst_in;
   logic [1:0]  st_ff, st_in;

   // multiply: four 16x16 partial products, summed next cycle
   logic [31:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [63:0] prod;
   logic [63:0] prod_fix;
   logic        mul_sign_ff;

   // divide: restoring, one bit a cycle on magnitudes
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [DivCountWidth-1:0] dcnt_ff;
   logic        dneg_q_ff, dneg_r_ff, dzero_ff;
   logic [32:0] dtrial;
   logic [31:0] rem_sh;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [15:0] imm;
   logic [31:0] simm, zimm, pc4;
   logic        sgn_fn;

   assign op   = instr_ff[31:26];
   assign rs   = instr_ff[25:21];
   assign rt   = instr_ff[20:16];
   assign rd   = instr_ff[15:11];
   assign sa   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign imm  = instr_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign zimm = {16'h0, imm};
   assign pc4  = pc_ff + 32'd4;
   assign sgn_fn = (fn == FN_MULT) || (fn == FN_DIV);

   assign stat.is_mul = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
   assign stat.is_div = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU);
   assign stat.div_last = (dcnt_ff == DivCountWidth'(32));

   always_ff @(posedge clock) begin
      if (cmd.latch_instr) instr_ff <= req_instruction_word;
      if (cmd.read_regs) begin
         a_raw <= rf_mem[rs];
         b_raw <= rf_mem[rt];
      end
      if (cmd.commit && wr_ff) rf_mem[dst_ff] <= val_ff;
   end

   assign a_ff = (valid_ff[rs] && rs != 5'd0) ? a_raw : 32'h0;
   assign b_ff = (valid_ff[rt] && rt != 5'd0) ? b_raw : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && wr_ff) begin
         valid_ff[dst_ff] <= 1'b1;
      end
   end

   // multiplier
   logic [31:0] ma, mb;
   assign ma = (sgn_fn && a_ff[31]) ? (32'h0 - a_ff) : a_ff;
   assign mb = (sgn_fn && b_ff[31]) ? (32'h0 - b_ff) : b_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         pp_ll_ff <= ma[15:0]  * mb[15:0];
         pp_lh_ff <= ma[15:0]  * mb[31:16];
         pp_hl_ff <= ma[31:16] * mb[15:0];
         pp_hh_ff <= ma[31:16] * mb[31:16];
         mul_sign_ff <= sgn_fn && (a_ff[31] ^ b_ff[31]);
      end
   end
   assign prod = {pp_hh_ff, pp_ll_ff} + {16'h0, pp_lh_ff, 16'h0}
               + {16'h0, pp_hl_ff, 16'h0};
   assign prod_fix = mul_sign_ff ? (64'h0 - prod) : prod;

   // divider
   assign rem_sh = {dr_ff[30:0], dq_ff[31]};
   assign dtrial = {1'b0, rem_sh} - {1'b0, dd_ff};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff <= ma;
         dr_ff <= '0;
         dd_ff <= mb;
         dcnt_ff <= '0;
         dneg_q_ff <= sgn_fn && (a_ff[31] ^ b_ff[31]);
         dneg_r_ff <= sgn_fn && a_ff[31];
         dzero_ff <= (b_ff == 32'h0);
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DivCountWidth'(1);
         if (!dtrial[32]) begin
            dr_ff <= dtrial[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= rem_sh;
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
      end
   end

   // execute
   always_comb begin
      npc_in = pc4;
      wr_in = 1'b1;
      dst_in = rt;
      val_in = '0;
      st_in = STATUS_OK;
      hi_in = hi_ff;
      lo_in = lo_ff;
      hilo_we = 1'b0;
      if (op == OP_SPECIAL) begin
         dst_in = rd;
         case (fn)
            FN_SLL:  val_in = b_ff << sa;
            FN_SRL:  val_in = b_ff >> sa;
            FN_SRA:  val_in = 32'($signed(b_ff) >>> sa);
            FN_SLLV: val_in = b_ff << a_ff[4:0];
            FN_SRLV: val_in = b_ff >> a_ff[4:0];
            FN_SRAV: val_in = 32'($signed(b_ff) >>> a_ff[4:0]);
            FN_JR:   begin wr_in = 1'b0; npc_in = a_ff; end
            FN_JALR: begin dst_in = 5'd31; val_in = pc4; npc_in = a_ff; end
            FN_MFHI: val_in = hi_ff;
            FN_MTHI: begin wr_in = 1'b0; hi_in = a_ff; hilo_we = 1'b1; end
            FN_MFLO: val_in = lo_ff;
            FN_MTLO: begin wr_in = 1'b0; lo_in = a_ff; hilo_we = 1'b1; end
            FN_MULT, FN_MULTU: begin
               wr_in = 1'b0; hilo_we = 1'b1;
               hi_in = prod_fix[63:32]; lo_in = prod_fix[31:0];
            end
            FN_DIV, FN_DIVU: begin
               wr_in = 1'b0; hilo_we = 1'b1;
               if (dzero_ff) begin
                  lo_in = 32'hFFFF_FFFF; hi_in = a_ff;
               end else begin
                  lo_in = dneg_q_ff ? (32'h0 - dq_ff) : dq_ff;
                  hi_in = dneg_r_ff ? (32'h0 - dr_ff) : dr_ff;
               end
            end
            FN_ADD, FN_ADDU: val_in = a_ff + b_ff;
            FN_SUB, FN_SUBU: val_in = a_ff - b_ff;
            FN_AND:  val_in = a_ff & b_ff;
            FN_OR:   val_in = a_ff | b_ff;
            FN_XOR:  val_in = a_ff ^ b_ff;
            FN_NOR:  val_in = ~(a_ff | b_ff);
            FN_SLT:  val_in = {31'h0, $signed(a_ff) < $signed(b_ff)};
            FN_SLTU: val_in = {31'h0, a_ff < b_ff};
            default: begin wr_in = 1'b0; st_in = STATUS_INVALID; end
         endcase
      end else begin
         case (op)
            OP_J:    begin wr_in = 1'b0; npc_in = pc4 + {4'h0, instr_ff[25:0], 2'b00}; end
            OP_JAL:  begin
               dst_in = 5'd31; val_in = pc4;
               npc_in = pc4 + {4'h0, instr_ff[25:0], 2'b00};
            end
            OP_BEQ:  begin wr_in = 1'b0; if (a_ff == b_ff) npc_in = pc4 + {simm[29:0], 2'b00}; end
            OP_BNE:  begin wr_in = 1'b0; if (a_ff != b_ff) npc_in = pc4 + {simm[29:0], 2'b00}; end
            OP_BLEZ: begin
               wr_in = 1'b0;
               if (a_ff == 32'h0 || a_ff[31]) npc_in = pc4 + {simm[29:0], 2'b00};
            end
            OP_BGTZ: begin
               wr_in = 1'b0;
               if (a_ff != 32'h0 && !a_ff[31]) npc_in = pc4 + {simm[29:0], 2'b00};
            end
            OP_ADDI, OP_ADDIU: val_in = a_ff + simm;
            OP_SLTI:  val_in = {31'h0, $signed(a_ff) < $signed(simm)};
            OP_SLTIU: val_in = {31'h0, a_ff < simm};
            OP_ANDI:  val_in = a_ff & zimm;
            OP_ORI:   val_in = a_ff | zimm;
            OP_XORI:  val_in = a_ff ^ zimm;
            OP_LLO:   val_in = {b_ff[31:16], imm};
            OP_LHI:   val_in = {imm, b_ff[15:0]};
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
               wr_in = 1'b0; st_in = STATUS_MEMORY;
            end
            default: begin wr_in = 1'b0; st_in = STATUS_INVALID; end
         endcase
      end
      if (!wr_in || dst_in == 5'd0) begin
         wr_in = 1'b0; dst_in = '0; val_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         npc_ff <= npc_in;
         wr_ff  <= wr_in;
         dst_ff <= dst_in;
         val_ff <= val_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
         pc_ff <= '0;
      end else begin
         if (cmd.exec && hilo_we) begin
            hi_ff <= hi_in;
            lo_ff <= lo_in;
         end
         if (csr_write) pc_ff <= csr_start_pc;
         else if (cmd.commit) pc_ff <= npc_ff;
      end
   end

   assign rsp_next_pc     = npc_ff;
   assign rsp_reg_written = wr_ff;
   assign rsp_reg_index   = dst_ff;
   assign rsp_reg_value   = val_ff;
   assign rsp_status      = st_ff;

endmodule

// ===== rtl/core/mips_integer_execute_step_unit.sv =====
// ----------------------------------------------------------------------------
// mips_integer_execute_step_unit
// Multicycle execute step of a small MIPS-like integer core.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one instruction word per transfer; taken only when idle.
//  - rsp_ channel: next PC, register write (index/value) and status per
//    instruction, held stable until the transfer completes.
//  - csr_ channel: writes start_pc, which also loads the PC at once.
//    Always ready; write only while no instruction is in flight.
// Sequence: the request transfer latches the instruction, the operands are
// read, then execute registers the response, which stays valid in the done
// state until the response transfer returns the unit to idle. MULT/MULTU
// add a state to sum the split 16x16 partial products; DIV/DIVU step the
// restoring divider, one quotient bit a cycle, before execute. One at a time.
// Reset: registers, HI, LO and PC clear to zero; register file entries are
// tracked by valid bits, so it reads zero without a clearing pass.
// Stall: while rsp_ready is low the result holds and no request is taken;
// register file and PC update on the response transfer, HI/LO at execute.
// ----------------------------------------------------------------------------
module mips_integer_execute_step_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_start_pc
);
   import mies_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // configuration transfers are always taken
   assign csr_ready = 1'b1;

   mies_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mies_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_instruction_word (req_instruction_word),
      .csr_write            (csr_valid),
      .csr_start_pc         (csr_start_pc),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_reg_written      (rsp_reg_written),
      .rsp_reg_index        (rsp_reg_index),
      .rsp_reg_value        (rsp_reg_value),
      .rsp_status           (rsp_status)
   );

endmodule
